// ===== hw/rtl/dssf_pkg.sv =====
package dssf_pkg;

  typedef struct packed {
    logic signed [23:0] scaled_value;
    logic [1:0]         frac_digits;
  } item_t;

  typedef struct packed {
    logic [7:0] seg_char0;
    logic [7:0] seg_char1;
    logic [7:0] seg_char2;
    logic [7:0] seg_char3;
    logic [7:0] seg_char4;
    logic [7:0] seg_char5;
  } result_t;

  typedef struct packed {
    logic            neg;
    logic            zpad;
    logic [1:0]      frac;
    logic [5:0][3:0] d;
  } digits_t;

  localparam int VALUE_MAX = 999999;
  localparam int VALUE_MIN = -99999;

  // Reciprocal of 1000 scaled by 2^30, exact for magnitudes below 2^20.
  localparam logic [20:0] RECIP_1000 = 21'd1073742;
  localparam logic [5:0]  RECIP_100  = 6'd41;
  localparam logic [7:0]  RECIP_10   = 8'd205;

  localparam logic [9:0] POW10 [4] = '{10'd1, 10'd10, 10'd100, 10'd1000};

  localparam logic [7:0] SEG_DIGIT [10] = '{
    8'h7D, 8'h60, 8'h3E, 8'h7A, 8'h63, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };
  localparam logic [7:0] SEG_SPACE = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h02;
  localparam logic [7:0] SEG_POINT = 8'h80;

endpackage

// ===== hw/rtl/dssf_digits.sv =====
module dssf_digits (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            item_valid,
  input  dssf_pkg::item_t item,
  output logic            digit_valid,
  output dssf_pkg::digits_t digits
);

  logic [6:1] valid;

  logic [19:0] s1_mag;
  logic        s1_neg;
  logic [1:0]  s1_frac;

  logic [9:0]  s2_hi;
  logic [19:0] s2_mag;
  logic        s2_neg;
  logic        s2_zpad;
  logic [1:0]  s2_frac;

  logic [1:0][9:0] s3_x;
  logic        s3_neg;
  logic        s3_zpad;
  logic [1:0]  s3_frac;

  logic [1:0][9:0] s4_x;
  logic [1:0][3:0] s4_h;
  logic        s4_neg;
  logic        s4_zpad;
  logic [1:0]  s4_frac;

  logic [1:0][3:0] s5_h;
  logic [1:0][6:0] s5_r;
  logic        s5_neg;
  logic        s5_zpad;
  logic [1:0]  s5_frac;

  logic [1:0][3:0] s6_h;
  logic [1:0][6:0] s6_r;
  logic [1:0][3:0] s6_t;
  logic        s6_neg;
  logic        s6_zpad;
  logic [1:0]  s6_frac;

  logic [19:0] mag_next;
  logic        neg_next;
  logic [23:0] abs_val;
  logic [40:0] prod_hi;
  logic [1:0][15:0] prod_h;
  logic [1:0][14:0] prod_t;

  always_comb begin
    abs_val = item.scaled_value[23] ? 24'(-item.scaled_value) : 24'(item.scaled_value);
    if (item.scaled_value > 24'(dssf_pkg::VALUE_MAX)) begin
      neg_next = 1'b0;
      mag_next = 20'(dssf_pkg::VALUE_MAX);
    end else if (item.scaled_value < $signed(24'(dssf_pkg::VALUE_MIN))) begin
      neg_next = 1'b1;
      mag_next = 20'(-dssf_pkg::VALUE_MIN);
    end else begin
      neg_next = item.scaled_value[23];
      mag_next = abs_val[19:0];
    end
  end

  assign prod_hi = 41'(s1_mag) * 41'(dssf_pkg::RECIP_1000);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod_h[k] = 16'(s3_x[k]) * 16'(dssf_pkg::RECIP_100);
      prod_t[k] = 15'(s5_r[k]) * 15'(dssf_pkg::RECIP_10);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[5:1], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag  <= mag_next;
      s1_neg  <= neg_next;
      s1_frac <= item.frac_digits;

      s2_hi   <= prod_hi[39:30];
      s2_mag  <= s1_mag;
      s2_neg  <= s1_neg;
      s2_frac <= s1_frac;
      s2_zpad <= (s1_frac != 2'd0) && (s1_mag < 20'(dssf_pkg::POW10[s1_frac]));

      s3_x[1] <= s2_hi;
      s3_x[0] <= 10'(s2_mag - 20'(s2_hi) * 20'd1000);
      s3_neg  <= s2_neg;
      s3_zpad <= s2_zpad;
      s3_frac <= s2_frac;

      for (int k = 0; k < 2; k++) begin
        s4_x[k] <= s3_x[k];
        s4_h[k] <= prod_h[k][15:12];
      end
      s4_neg  <= s3_neg;
      s4_zpad <= s3_zpad;
      s4_frac <= s3_frac;

      for (int k = 0; k < 2; k++) begin
        s5_h[k] <= s4_h[k];
        s5_r[k] <= 7'(s4_x[k] - 10'(s4_h[k]) * 10'd100);
      end
      s5_neg  <= s4_neg;
      s5_zpad <= s4_zpad;
      s5_frac <= s4_frac;

      for (int k = 0; k < 2; k++) begin
        s6_h[k] <= s5_h[k];
        s6_r[k] <= s5_r[k];
        s6_t[k] <= prod_t[k][14:11];
      end
      s6_neg  <= s5_neg;
      s6_zpad <= s5_zpad;
      s6_frac <= s5_frac;

      digits.neg  <= s6_neg;
      digits.zpad <= s6_zpad;
      digits.frac <= s6_frac;
      digits.d[0] <= s6_h[1];
      digits.d[1] <= s6_t[1];
      digits.d[2] <= 4'(s6_r[1] - 7'(s6_t[1]) * 7'd10);
      digits.d[3] <= s6_h[0];
      digits.d[4] <= s6_t[0];
      digits.d[5] <= 4'(s6_r[0] - 7'(s6_t[0]) * 7'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (en) begin
      digit_valid <= valid[6];
    end
  end

endmodule

// ===== hw/rtl/decimal_seven_segment_formatter.sv =====
// Decimal seven-segment formatter.
// The item channel (item_valid, item_stall, item) carries a signed value already
// scaled by ten to the power of frac_digits, plus frac_digits from 0 to 3. The result
// channel (result_valid, result_stall, result) carries six segment bytes, leftmost
// character first, with bit 7 as the decimal point.
// The value is clamped to -99999..999999 and shown right-aligned with a minus sign,
// zero-padded when a point is shown and the magnitude is below one whole unit.
// An item transfer's result becomes valid after the eight register stages of the
// clamp, reciprocal-multiply digit split and character encoding pipeline. One item
// can be taken every cycle while a result stall does not hold the pipeline.
// When the receiver asserts result_stall while a result is valid, the whole pipeline
// holds and item_stall is raised in the same cycle; nothing is lost or repeated.
// A synchronous reset clears all valid bits, so no result appears until new items
// have been transferred.
module decimal_seven_segment_formatter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dssf_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output dssf_pkg::result_t result
);

  logic              en;
  logic              digit_valid;
  dssf_pkg::digits_t digits;
  logic [5:0][7:0]   seg;
  logic [5:0]        lead;
  dssf_pkg::result_t result_next;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  dssf_digits u_digits (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .item_valid  (item_valid),
    .item        (item),
    .digit_valid (digit_valid),
    .digits      (digits)
  );

  always_comb begin
    lead[0] = (digits.d[0] == 4'd0);
    for (int i = 1; i < 6; i++) begin
      lead[i] = lead[i-1] && (digits.d[i] == 4'd0);
    end
    for (int i = 0; i < 6; i++) begin
      if (digits.zpad && !digits.neg) begin
        seg[i] = (i < 5 - int'(digits.frac)) ? dssf_pkg::SEG_SPACE
                                              : dssf_pkg::SEG_DIGIT[digits.d[i]];
      end else if (digits.zpad) begin
        seg[i] = (i == 0) ? dssf_pkg::SEG_MINUS : dssf_pkg::SEG_DIGIT[digits.d[i]];
      end else if (i < 5 && lead[i]) begin
        seg[i] = (digits.neg && !lead[i+1]) ? dssf_pkg::SEG_MINUS : dssf_pkg::SEG_SPACE;
      end else begin
        seg[i] = dssf_pkg::SEG_DIGIT[digits.d[i]];
      end
      if (digits.frac != 2'd0 && i == 6 - int'(digits.frac)) begin
        seg[i] = seg[i] | dssf_pkg::SEG_POINT;
      end
    end
    result_next.seg_char0 = seg[0];
    result_next.seg_char1 = seg[1];
    result_next.seg_char2 = seg[2];
    result_next.seg_char3 = seg[3];
    result_next.seg_char4 = seg[4];
    result_next.seg_char5 = seg[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= digit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// ===== sim/decimal_seven_segment_formatter_tb.sv =====
`timescale 1ns / 1ps

module decimal_seven_segment_formatter_tb;

  localparam int CHAR_SPACE = 10;
  localparam int CHAR_MINUS = 11;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    dssf_pkg::item_t payload;
    bit              drain;
  } pending_t;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  dssf_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  dssf_pkg::result_t result;

  pending_t          pending_items[$];
  dssf_pkg::result_t expected_segments[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  clamped_items = 0;
  int  frac_count[4] = '{0, 0, 0, 0};
  logic tx_took = 1'b0;
  logic rx_took = 1'b0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_busy = 1'b1;
  bit  rx_busy = 1'b1;
  int  hold_left = 0;
  int  hold_stage = 0;

  decimal_seven_segment_formatter u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic dssf_pkg::result_t format_segments(dssf_pkg::item_t it);
    int value;
    int mag;
    int unit;
    int pos;
    int p;
    int k;
    int ch[6];
    bit neg;
    bit blanking;
    logic [5:0][7:0] segs;
    value = $signed(it.scaled_value);
    p = it.frac_digits;
    if (value > dssf_pkg::VALUE_MAX) value = dssf_pkg::VALUE_MAX;
    if (value < dssf_pkg::VALUE_MIN) value = dssf_pkg::VALUE_MIN;
    unit = 1;
    for (k = 0; k < p; k++) unit = unit * 10;
    neg = value < 0;
    mag = neg ? -value : value;
    if (p > 0 && mag < unit) begin
      for (k = 5; k >= 0; k--) begin
        ch[k] = mag % 10;
        mag = mag / 10;
      end
      if (neg) ch[0] = CHAR_MINUS;
    end else begin
      for (k = 0; k < 6; k++) ch[k] = CHAR_SPACE;
      pos = 5;
      do begin
        ch[pos] = mag % 10;
        mag = mag / 10;
        pos--;
      end while (mag != 0 && pos >= 0);
      if (neg && pos >= 0) ch[pos] = CHAR_MINUS;
    end
    if (p > 0 && value < unit) begin
      blanking = 1'b1;
      for (k = 0; k < 5 - p; k++) begin
        if (blanking) begin
          if (ch[k + 1] == 0 && ch[k] != CHAR_MINUS) ch[k] = CHAR_SPACE;
          else blanking = 1'b0;
        end
      end
    end
    for (k = 0; k < 6; k++) begin
      if (ch[k] < 10) segs[5 - k] = dssf_pkg::SEG_DIGIT[ch[k]];
      else if (ch[k] == CHAR_MINUS) segs[5 - k] = dssf_pkg::SEG_MINUS;
      else segs[5 - k] = dssf_pkg::SEG_SPACE;
      if (p > 0 && k == 6 - p) segs[5 - k] = segs[5 - k] | dssf_pkg::SEG_POINT;
    end
    return dssf_pkg::result_t'(segs);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic add_item(input int value, input int frac, input bit drain);
    pending_t entry;
    entry.payload.scaled_value = value[23:0];
    entry.payload.frac_digits = frac[1:0];
    entry.drain = drain;
    pending_items.push_back(entry);
    if ($signed(value[23:0]) > dssf_pkg::VALUE_MAX ||
        $signed(value[23:0]) < dssf_pkg::VALUE_MIN) clamped_items++;
    frac_count[frac[1:0]]++;
  endtask

  // Results are checked before new expectations are queued, so a result can never
  // be matched against an item transferred in the same cycle.
  always @(posedge clk) begin : check
    logic [5:0][7:0] got_b;
    logic [5:0][7:0] want_b;
    int k;
    cycle_count++;
    if (rst) begin
      tx_took <= 1'b0;
      rx_took <= 1'b0;
    end else begin
      rx_took <= result_valid && !result_stall;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_segments.size() == 0) begin
          report_mismatch("result transfer with no expectation pending");
        end else begin
          want_b = expected_segments.pop_front();
          got_b = result;
          for (k = 0; k < 6; k++) begin
            if (got_b[5 - k] !== want_b[5 - k]) begin
              report_mismatch($sformatf("result %0d seg_char%0d got %02h expected %02h",
                                        results_seen, k, got_b[5 - k], want_b[5 - k]));
            end
          end
        end
      end
      tx_took <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        expected_segments.push_back(format_segments(item));
        items_sent++;
      end
    end
  end

  always @(negedge clk) begin : drive
    logic offer;
    pending_t next_entry;
    if (!rst) begin
      offer = item_valid;
      if (tx_took) begin
        offer = 1'b0;
        tx_wait = tx_busy ? $urandom_range(0, 7) : 0;
        if ($urandom_range(0, 39) == 0) tx_busy = !tx_busy;
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_segments.size() != 0)) begin
          next_entry = pending_items.pop_front();
          item <= next_entry.payload;
          offer = 1'b1;
        end
      end
      item_valid <= offer;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (rx_took) begin
        rx_wait = rx_busy ? $urandom_range(0, 7) : 0;
        if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
      end
      if ((hold_stage == 0 && results_seen >= 150) ||
          (hold_stage == 1 && results_seen >= 700)) begin
        hold_left = LONG_HOLD;
        hold_stage++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
             expected_segments.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    int sel;
    int value;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;

    add_item(8388607, 0, 1'b0);
    add_item(-8388608, 1, 1'b0);
    add_item(999999, 0, 1'b0);
    add_item(1000000, 2, 1'b0);
    add_item(-99999, 0, 1'b0);
    add_item(-100000, 3, 1'b0);
    add_item(0, 0, 1'b0);
    add_item(0, 1, 1'b0);
    add_item(0, 2, 1'b0);
    add_item(0, 3, 1'b0);
    add_item(-1, 1, 1'b0);
    add_item(-5, 2, 1'b0);
    add_item(-7, 3, 1'b0);
    add_item(9, 1, 1'b0);
    add_item(10, 1, 1'b0);
    add_item(99, 2, 1'b0);
    add_item(100, 2, 1'b0);
    add_item(999, 3, 1'b0);
    add_item(1000, 3, 1'b0);
    add_item(-999, 3, 1'b0);
    add_item(-1000, 3, 1'b0);
    add_item(123456, 3, 1'b0);
    add_item(-12345, 2, 1'b0);
    add_item(5, 3, 1'b0);
    add_item(-10, 1, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 5) value = $urandom();
      else if (sel < 12) value = $urandom_range(0, 2200) - 1100;
      else if (sel < 18) value = $urandom_range(0, 1100000) - 100000;
      else value = (sel == 18 ? 999999 : -99999) + $urandom_range(0, 4) - 2;
      add_item(value, $urandom_range(0, 3), n == 0 || n % 400 == 399);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results; %0d items were out of range.",
             items_sent, results_seen, clamped_items);
    $display("Items per point position 0..3: %0d %0d %0d %0d; mismatches: %0d.",
             frac_count[0], frac_count[1], frac_count[2], frac_count[3], error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== decimal_seven_segment_formatter.f =====
hw/rtl/dssf_pkg.sv
hw/rtl/dssf_digits.sv
hw/rtl/decimal_seven_segment_formatter.sv
sim/decimal_seven_segment_formatter_tb.sv
